>>> hdl/assert_macros.svh
// Assertion helpers shared by the heading block.
// All checks are clocked on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check
`define DGH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication check
`define DGH_ASSERT_IMP(label, ante, cons, msg) \
  `DGH_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> hdl/dgh_pkg.sv
package dgh_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 24;
  localparam int CFG_W       = 24;
  localparam int HEAD_W      = 16;
  localparam int AXES        = 2;

  // Degauss hold
  localparam int HOLD_SAMPLES = 4;
  localparam int HOLD_W       = $clog2(HOLD_SAMPLES + 1);
  localparam int THR_CMP_W    = (SAMPLE_BITS + 1 > CFG_W) ? SAMPLE_BITS + 1 : CFG_W;

  // Correction datapath
  localparam int DIFF_W   = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 1;
  localparam int PROD_W   = DIFF_W + CFG_W + 1;
  localparam int NORM_EXP = 48;
  localparam int VEC_W    = ((PROD_W > NORM_EXP + 2) ? PROD_W : NORM_EXP + 2) + 3;

  // Normalization runs as a binary search over doubling counts
  localparam int NORM_STEPS = 6;
  localparam int NSTEP_W    = $clog2(NORM_STEPS);
  localparam int NSHIFT_W   = 6;
  localparam int NORM_SHIFTS [NORM_STEPS] = '{32, 16, 8, 4, 2, 1};

  // CORDIC, angles in units of 2^-24 turn
  localparam int CORDIC_STEPS = 22;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int TURN_W       = 24;
  localparam logic [TURN_W-1:0] HALF_TURN    = TURN_W'(24'h800000);
  localparam logic [TURN_W-1:0] HEADING_BASE = TURN_W'(12449403);
  localparam int HEAD_ROUND = 128;
  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718,   24'd20860,   24'd10430,  24'd5215,   24'd2608,   24'd1304,
    24'd652,     24'd326,     24'd163,    24'd81,     24'd41,     24'd20,
    24'd10,      24'd5,       24'd3,      24'd1
  };

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + HEAD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + 2 * HEAD_W + 7) / 8) * 8;

  // Register map
  localparam int NUM_REGS   = 5;
  localparam int CFG_ADDR_W = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam int APB_W      = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_OFFSET  = 3'd0,
    REG_Y_OFFSET  = 3'd1,
    REG_X_SCALE   = 3'd2,
    REG_Y_SCALE   = 3'd3,
    REG_THRESHOLD = 3'd4
  } reg_idx_t;

  localparam logic [CFG_W-1:0] X_OFFSET_RST  = CFG_W'(151);
  localparam logic [CFG_W-1:0] Y_OFFSET_RST  = CFG_W'(243);
  localparam logic [CFG_W-1:0] X_SCALE_RST   = CFG_W'(189713);
  localparam logic [CFG_W-1:0] Y_SCALE_RST   = CFG_W'(153987);
  localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(96);

  typedef struct packed {
    logic signed [CFG_W-1:0] x_offset;
    logic signed [CFG_W-1:0] y_offset;
    logic [CFG_W-1:0]        x_scale;
    logic [CFG_W-1:0]        y_scale;
    logic [CFG_W-1:0]        threshold;
  } cfg_t;

  // One cleaned sample on its way to the back end
  typedef struct packed {
    logic [HEAD_W-1:0]             sensor_heading;
    logic signed [SAMPLE_BITS-1:0] clean_y;
    logic signed [SAMPLE_BITS-1:0] clean_x;
  } item_t;

endpackage

>>> hdl/dgh_queue.sv
`include "assert_macros.svh"

module dgh_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  dgh_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dgh_pkg::item_t  pop_item
);

  dgh_pkg::item_t                   slot_r [dgh_pkg::QUEUE_DEPTH];
  logic [dgh_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dgh_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dgh_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             do_push, do_pop;

  assign push_ready = (count_r != dgh_pkg::QCNT_W'(dgh_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == dgh_pkg::QPTR_W'(dgh_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == dgh_pkg::QPTR_W'(dgh_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `DGH_ASSERT(a_q_count_bound, count_r <= dgh_pkg::QCNT_W'(dgh_pkg::QUEUE_DEPTH), "queue overfilled")
  `DGH_ASSERT_IMP(a_q_ptr_gap, count_r == '0, wr_ptr_r == rd_ptr_r, "queue pointers out of step")

endmodule

>>> hdl/dgh_front.sv
`include "assert_macros.svh"

module dgh_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dgh_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [dgh_pkg::CFG_W-1:0]          threshold,
  output logic                               push_valid,
  input  logic                               push_ready,
  output dgh_pkg::item_t                     push_item
);

  localparam int SB = dgh_pkg::SAMPLE_BITS;

  logic signed [SB-1:0]                 smp        [dgh_pkg::AXES];
  logic signed [SB-1:0]                 prev_r     [dgh_pkg::AXES];
  logic signed [SB-1:0]                 prev_nxt   [dgh_pkg::AXES];
  logic signed [SB:0]                   jump_r     [dgh_pkg::AXES];
  logic signed [SB:0]                   jump_nxt   [dgh_pkg::AXES];
  logic [dgh_pkg::HOLD_W-1:0]           hold_r     [dgh_pkg::AXES];
  logic [dgh_pkg::HOLD_W-1:0]           hold_nxt   [dgh_pkg::AXES];
  logic                                 held_r     [dgh_pkg::AXES];
  logic                                 held_nxt   [dgh_pkg::AXES];
  logic [dgh_pkg::HOLD_W-1:0]           hold_use   [dgh_pkg::AXES];
  logic [SB:0]                          jump_abs   [dgh_pkg::AXES];
  logic signed [SB+1:0]                 diff       [dgh_pkg::AXES];
  logic signed [SB-1:0]                 diff_sat   [dgh_pkg::AXES];
  logic signed [SB-1:0]                 clean      [dgh_pkg::AXES];
  logic                                 accept;

  assign smp[0] = in_tdata[SB-1:0];
  assign smp[1] = in_tdata[2*SB-1:SB];

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;

  assign push_item.clean_x        = clean[0];
  assign push_item.clean_y        = clean[1];
  assign push_item.sensor_heading = in_tdata[2*SB+dgh_pkg::HEAD_W-1:2*SB];

  // Per axis: measure the jump, run the hold, subtract and saturate
  always_comb begin
    for (int a = 0; a < dgh_pkg::AXES; a++) begin
      jump_nxt[a] = jump_r[a];
      hold_use[a] = hold_r[a];
      if (hold_r[a] == '0 && !held_r[a]) begin
        jump_nxt[a] = {smp[a][SB-1], smp[a]} - {prev_r[a][SB-1], prev_r[a]};
      end
      jump_abs[a] = jump_nxt[a][SB] ? -jump_nxt[a] : jump_nxt[a];
      if (hold_r[a] == '0 && !held_r[a] &&
          dgh_pkg::THR_CMP_W'(jump_abs[a]) > dgh_pkg::THR_CMP_W'(threshold)) begin
        hold_use[a] = dgh_pkg::HOLD_W'(dgh_pkg::HOLD_SAMPLES);
      end
      diff[a] = {{2{smp[a][SB-1]}}, smp[a]} - {jump_nxt[a][SB], jump_nxt[a]};
      if (diff[a][SB+1] == diff[a][SB] && diff[a][SB] == diff[a][SB-1]) begin
        diff_sat[a] = diff[a][SB-1:0];
      end else if (diff[a][SB+1]) begin
        diff_sat[a] = {1'b1, {(SB-1){1'b0}}};
      end else begin
        diff_sat[a] = {1'b0, {(SB-1){1'b1}}};
      end
      if (hold_use[a] != '0) begin
        clean[a]    = diff_sat[a];
        hold_nxt[a] = hold_use[a] - 1'b1;
        held_nxt[a] = 1'b1;
      end else begin
        clean[a]    = smp[a];
        hold_nxt[a] = hold_use[a];
        held_nxt[a] = 1'b0;
      end
      prev_nxt[a] = clean[a];
    end
  end

  // Commit axis state on each accepted request
  always_ff @(posedge clk) begin
    for (int a = 0; a < dgh_pkg::AXES; a++) begin
      if (!rst_n) begin
        prev_r[a] <= '0;
        jump_r[a] <= '0;
        hold_r[a] <= '0;
        held_r[a] <= 1'b0;
      end else if (accept) begin
        prev_r[a] <= prev_nxt[a];
        jump_r[a] <= jump_nxt[a];
        hold_r[a] <= hold_nxt[a];
        held_r[a] <= held_nxt[a];
      end
    end
  end

  `DGH_ASSERT(a_hold_bound, (hold_r[0] < dgh_pkg::HOLD_W'(dgh_pkg::HOLD_SAMPLES)) && (hold_r[1] < dgh_pkg::HOLD_W'(dgh_pkg::HOLD_SAMPLES)), "hold count beyond range")
  `DGH_ASSERT_IMP(a_hold_marks_held, hold_r[0] != '0, held_r[0], "x hold running without held flag")

endmodule

>>> hdl/dgh_back.sv
`include "assert_macros.svh"

module dgh_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dgh_pkg::cfg_t                      cfg,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  dgh_pkg::item_t                     pop_item,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dgh_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int SB = dgh_pkg::SAMPLE_BITS;
  localparam int VW = dgh_pkg::VEC_W;
  localparam int TW = dgh_pkg::TURN_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL_X = 7'b0000010,
    ST_MUL_Y = 7'b0000100,
    ST_NORM  = 7'b0001000,
    ST_ROT   = 7'b0010000,
    ST_ITER  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [dgh_pkg::NSTEP_W-1:0]           nstep_r, nstep_nxt;
  logic [dgh_pkg::STEP_W-1:0]            step_r, step_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  dgh_pkg::item_t                        item_r, item_nxt;
  logic signed [dgh_pkg::DIFF_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [VW-1:0]                  x_r, x_nxt, y_r, y_nxt;
  logic [TW-1:0]                         z_r, z_nxt;
  logic [dgh_pkg::HEAD_W-1:0]            head_r, head_nxt;
  dgh_pkg::item_t                        res_r, res_nxt;

  logic signed [dgh_pkg::DIFF_W-1:0]     mul_a;
  logic signed [dgh_pkg::CFG_W:0]        mul_b;
  logic signed [dgh_pkg::PROD_W-1:0]     prod;
  logic [dgh_pkg::NSHIFT_W-1:0]          shamt;
  logic [VW-1:0]                         ax, ay, lim;
  logic signed [VW-1:0]                  sx, sy;
  logic [TW-1:0]                         head_turn;
  logic [TW:0]                           head_sum;

  // Shared multiplier: one axis per cycle
  assign mul_a = (state_r == ST_MUL_X) ? dx_r : dy_r;
  assign mul_b = (state_r == ST_MUL_X) ? {1'b0, cfg.x_scale} : {1'b0, cfg.y_scale};
  assign prod  = mul_a * mul_b;

  // Normalization step: magnitudes and the limit for this shift
  assign shamt = dgh_pkg::NSHIFT_W'(dgh_pkg::NORM_SHIFTS[nstep_r]);
  assign ax    = x_r[VW-1] ? -x_r : x_r;
  assign ay    = y_r[VW-1] ? -y_r : y_r;
  assign lim   = VW'(1) << (dgh_pkg::NORM_EXP + 1 - shamt);

  // CORDIC shifted terms, rounded toward minus infinity
  assign sx = x_r >>> step_r;
  assign sy = y_r >>> step_r;

  // Heading from the final angle, rounded to 16 bits
  assign head_turn = dgh_pkg::HEADING_BASE - z_r;
  assign head_sum  = {1'b0, head_turn} + (TW + 1)'(dgh_pkg::HEAD_ROUND);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dgh_pkg::OUT_TDATA_W'({res_r.sensor_heading, res_r.clean_y,
                                             res_r.clean_x, head_r});

  always_comb begin
    state_nxt     = state_r;
    nstep_nxt     = nstep_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    item_nxt      = item_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    head_nxt      = head_r;
    res_nxt       = res_r;
    pop_ready     = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Take the next sample and remove the offsets
      ST_IDLE: begin
        if (pop_valid) begin
          pop_ready = 1'b1;
          item_nxt  = pop_item;
          dx_nxt = {{(dgh_pkg::DIFF_W-SB){pop_item.clean_x[SB-1]}}, pop_item.clean_x} -
                   {{(dgh_pkg::DIFF_W-dgh_pkg::CFG_W){cfg.x_offset[dgh_pkg::CFG_W-1]}},
                    cfg.x_offset};
          dy_nxt = {{(dgh_pkg::DIFF_W-SB){pop_item.clean_y[SB-1]}}, pop_item.clean_y} -
                   {{(dgh_pkg::DIFF_W-dgh_pkg::CFG_W){cfg.y_offset[dgh_pkg::CFG_W-1]}},
                    cfg.y_offset};
          state_nxt = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        x_nxt     = {{(VW-dgh_pkg::PROD_W){prod[dgh_pkg::PROD_W-1]}}, prod};
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        y_nxt     = {{(VW-dgh_pkg::PROD_W){prod[dgh_pkg::PROD_W-1]}}, prod};
        nstep_nxt = '0;
        state_nxt = ST_NORM;
      end
      // Double both values until one magnitude reaches the limit
      ST_NORM: begin
        if (ax < lim && ay < lim) begin
          x_nxt = x_r <<< shamt;
          y_nxt = y_r <<< shamt;
        end
        if (nstep_r == dgh_pkg::NSTEP_W'(dgh_pkg::NORM_STEPS - 1)) begin
          state_nxt = ST_ROT;
        end else begin
          nstep_nxt = nstep_r + 1'b1;
        end
      end
      // Zero vector gives angle zero; negative x turns by a half turn
      ST_ROT: begin
        step_nxt = '0;
        z_nxt    = '0;
        if (x_r == '0 && y_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          if (x_r[VW-1]) begin
            x_nxt = -x_r;
            y_nxt = -y_r;
            z_nxt = dgh_pkg::HALF_TURN;
          end
          state_nxt = ST_ITER;
        end
      end
      // One vectoring micro-rotation per cycle
      ST_ITER: begin
        if (!y_r[VW-1]) begin
          x_nxt = x_r + sy;
          y_nxt = y_r - sx;
          z_nxt = z_r + dgh_pkg::ATAN_TURNS[step_r];
        end else begin
          x_nxt = x_r - sy;
          y_nxt = y_r + sx;
          z_nxt = z_r - dgh_pkg::ATAN_TURNS[step_r];
        end
        if (step_r == dgh_pkg::STEP_W'(dgh_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      // Hold until the output register is free
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          head_nxt      = head_sum[TW-1:TW-dgh_pkg::HEAD_W];
          res_nxt       = item_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nstep_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nstep_r     <= nstep_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    head_r <= head_nxt;
    res_r  <= res_nxt;
  end

  `DGH_ASSERT_IMP(a_iter_bound, state_r == ST_ITER, step_r < dgh_pkg::STEP_W'(dgh_pkg::CORDIC_STEPS), "CORDIC step beyond table")
  `DGH_ASSERT_IMP(a_pop_idle, pop_ready, state_r == ST_IDLE && pop_valid, "pop outside idle")

endmodule

>>> hdl/magnetometer_degauss_heading.sv
// An accepted input goes through the queue, then the back end's IDLE, MUL_X,
// MUL_Y, NORM, ROT, ITER and FIN states; a zero corrected vector skips ITER.
// FIN waits out output stalls. The queue buffers samples while the 22-step
// CORDIC loop, 6-step normalizer and shared multiplier work on the last one.
// Synchronous active-low reset clears the degauss state, the queue, the
// state machine and output valid; config registers return to default values.
module magnetometer_degauss_heading (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: mag_x, mag_y, sensor_heading_in (lowest bits first)
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dgh_pkg::IN_TDATA_W-1:0]      in_tdata,
  // tdata: heading, clean_x, clean_y, sensor_heading_out (lowest bits first)
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dgh_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [dgh_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [dgh_pkg::APB_W-1:0]           cfg_pwdata,
  output logic [dgh_pkg::APB_W-1:0]           cfg_prdata,
  output logic                                cfg_pready
);

  dgh_pkg::cfg_t     cfg_r, cfg_nxt;
  dgh_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  dgh_pkg::item_t    push_item, pop_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = dgh_pkg::reg_idx_t'(cfg_paddr[dgh_pkg::CFG_ADDR_W-1:2]);

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        dgh_pkg::REG_X_OFFSET:  cfg_nxt.x_offset  = cfg_pwdata[dgh_pkg::CFG_W-1:0];
        dgh_pkg::REG_Y_OFFSET:  cfg_nxt.y_offset  = cfg_pwdata[dgh_pkg::CFG_W-1:0];
        dgh_pkg::REG_X_SCALE:   cfg_nxt.x_scale   = cfg_pwdata[dgh_pkg::CFG_W-1:0];
        dgh_pkg::REG_Y_SCALE:   cfg_nxt.y_scale   = cfg_pwdata[dgh_pkg::CFG_W-1:0];
        dgh_pkg::REG_THRESHOLD: cfg_nxt.threshold = cfg_pwdata[dgh_pkg::CFG_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      dgh_pkg::REG_X_OFFSET:  cfg_prdata = dgh_pkg::APB_W'(cfg_r.x_offset);
      dgh_pkg::REG_Y_OFFSET:  cfg_prdata = dgh_pkg::APB_W'(cfg_r.y_offset);
      dgh_pkg::REG_X_SCALE:   cfg_prdata = dgh_pkg::APB_W'(cfg_r.x_scale);
      dgh_pkg::REG_Y_SCALE:   cfg_prdata = dgh_pkg::APB_W'(cfg_r.y_scale);
      dgh_pkg::REG_THRESHOLD: cfg_prdata = dgh_pkg::APB_W'(cfg_r.threshold);
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_offset  <= dgh_pkg::X_OFFSET_RST;
      cfg_r.y_offset  <= dgh_pkg::Y_OFFSET_RST;
      cfg_r.x_scale   <= dgh_pkg::X_SCALE_RST;
      cfg_r.y_scale   <= dgh_pkg::Y_SCALE_RST;
      cfg_r.threshold <= dgh_pkg::THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dgh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .threshold  (cfg_r.threshold),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dgh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dgh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/sv/magnetometer_degauss_heading_tb.sv
module magnetometer_degauss_heading_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dgh_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 80;
  localparam int RX_HOLD_OFF_CYCLES = 400;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int NUM_DIRECTED = 25;

  // Degauss and heading constants
  localparam int HOLD_LEN = 4;
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;
  localparam longint NORM_BOUND = 64'sd1 << 48;
  localparam int ARCTAN_STEPS = 22;
  localparam logic [23:0] HALF_REV = 24'h800000;
  localparam logic [23:0] HEADING_ZERO = 24'd12449403;
  localparam logic [23:0] ARCTAN_TURNS [ARCTAN_STEPS] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718,   24'd20860,   24'd10430,  24'd5215,   24'd2608,   24'd1304,
    24'd652,     24'd326,     24'd163,    24'd81,     24'd41,     24'd20,
    24'd10,      24'd5,       24'd3,      24'd1
  };
  // Heading of a zero corrected vector: angle 0 turned into the output frame
  localparam int ZERO_VECTOR_HEADING = 48630;
  localparam int SAMPLE_TOP = 8388607;
  localparam int SAMPLE_BOTTOM = -8388608;
  localparam int CFG_FULL = 16777215;
  // Register index past the end of the map, must be ignored
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
    logic [HEAD_W-1:0]             sensor_heading;
  } mag_sample_t;

  typedef struct {
    logic [HEAD_W-1:0]             heading;
    logic signed [SAMPLE_BITS-1:0] clean_x;
    logic signed [SAMPLE_BITS-1:0] clean_y;
    logic [HEAD_W-1:0]             sensor_heading;
  } fix_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [REG_IDX_W-1:0] idx;
    int                   value;
    int                   mx;
    int                   my;
    int                   hdg;
    bit                   pinned;
    int                   e_head;
    int                   e_cx;
    int                   e_cy;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // tdata: mag_x, mag_y, sensor_heading_in (lowest bits first)
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // tdata: heading, clean_x, clean_y, sensor_heading_out (lowest bits first)
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_W-1:0] cfg_pwdata = '0;
  logic [APB_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Calibration registers as the predictor sees them
  logic signed [CFG_W-1:0] cal_x_offset = X_OFFSET_RST;
  logic signed [CFG_W-1:0] cal_y_offset = Y_OFFSET_RST;
  logic [CFG_W-1:0] cal_x_scale = X_SCALE_RST;
  logic [CFG_W-1:0] cal_y_scale = Y_SCALE_RST;
  logic [CFG_W-1:0] cal_threshold = THRESHOLD_RST;

  // Per-axis degauss tracking
  longint prev_clean [2] = '{0, 0};
  longint jump_size [2] = '{0, 0};
  int hold_left [2] = '{0, 0};
  bit held_last [2] = '{1'b0, 1'b0};

  fix_t fixes_due [$];
  int mismatch_count = 0;
  int samples_sent = 0;
  int holds_started = 0;
  int settings_applied = 0;
  bit rx_bursts = 1'b0;
  bit rx_hold_off = 1'b0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // Zero scales and the widest threshold: every heading is the zero-vector one
    '{ROW_WRITE,  REG_THRESHOLD, CFG_FULL, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE,  REG_X_SCALE,   0,        0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE,  REG_Y_SCALE,   0,        0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 0, 0, 0, 1'b1, ZERO_VECTOR_HEADING, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, SAMPLE_TOP, SAMPLE_BOTTOM, 36000, 1'b1,
      ZERO_VECTOR_HEADING, SAMPLE_TOP, SAMPLE_BOTTOM},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, SAMPLE_BOTTOM, SAMPLE_TOP, 65535, 1'b1,
      ZERO_VECTOR_HEADING, SAMPLE_BOTTOM, SAMPLE_TOP},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, -1, 1, 36001, 1'b1, ZERO_VECTOR_HEADING, -1, 1},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 5592405, -5592406, 21845, 1'b1,
      ZERO_VECTOR_HEADING, 5592405, -5592406},
    // Write past the register map, then prove nothing moved
    '{ROW_WRITE,  REG_UNMAPPED, CFG_FULL, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 0, 0, 0, 1'b1, ZERO_VECTOR_HEADING, 0, 0},
    // Back to the power-up calibration
    '{ROW_WRITE,  REG_X_OFFSET,  151,    0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE,  REG_Y_OFFSET,  243,    0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE,  REG_X_SCALE,   189713, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE,  REG_Y_SCALE,   153987, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE,  REG_THRESHOLD, 96,     0, 0, 0, 1'b0, 0, 0, 0},
    // Jumps at and below the threshold, then full-scale jumps that saturate
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 50, -96, 100, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, SAMPLE_TOP, SAMPLE_BOTTOM, 1234, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, SAMPLE_BOTTOM, SAMPLE_TOP, 18000, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 0, 0, 9000, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 100, -100, 27000, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 100, -100, 35999, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 251, 143, 4500, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, -70000, 90000, 30, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, -151, -243, 7, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, REG_UNMAPPED, 0, 151, 243, 0, 1'b0, 0, 0, 0}
  };

  magnetometer_degauss_heading i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint signed_span(longint amp);
    return longint'($urandom_range(0, 32'(2 * amp))) - amp;
  endfunction

  // Remove a degauss jump from one axis and advance its hold state
  function automatic longint degauss_axis(int a, longint raw);
    longint c;
    c = raw;
    if (hold_left[a] == 0 && !held_last[a]) begin
      jump_size[a] = raw - prev_clean[a];
      if (abs64(jump_size[a]) > longint'(cal_threshold)) begin
        hold_left[a] = HOLD_LEN;
        holds_started++;
      end
    end
    held_last[a] = 1'b0;
    if (hold_left[a] > 0) begin
      c = raw - jump_size[a];
      if (c > SAMPLE_MAX) c = SAMPLE_MAX;
      if (c < SAMPLE_MIN) c = SAMPLE_MIN;
      hold_left[a]--;
      held_last[a] = 1'b1;
    end
    prev_clean[a] = c;
    return c;
  endfunction

  // Clean, correct and resolve one sample into a heading fix
  function automatic fix_t predict_fix(mag_sample_t s);
    fix_t f;
    longint cx, cy, vx, vy, dx, dy;
    logic [23:0] z, h;
    logic [24:0] rounded;
    int i;
    cx = degauss_axis(AXIS_X, longint'(s.mag_x));
    cy = degauss_axis(AXIS_Y, longint'(s.mag_y));
    vx = (cx - longint'(cal_x_offset)) * longint'(cal_x_scale);
    vy = (cy - longint'(cal_y_offset)) * longint'(cal_y_scale);
    z = '0;
    if (vx != 0 || vy != 0) begin
      // Normalize so the CORDIC keeps full precision
      while (abs64(vx) < NORM_BOUND && abs64(vy) < NORM_BOUND) begin
        vx = vx * 2;
        vy = vy * 2;
      end
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        z = HALF_REV;
      end
      for (i = 0; i < ARCTAN_STEPS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx = vx + dx;
          vy = vy - dy;
          z = z + ARCTAN_TURNS[i];
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          z = z - ARCTAN_TURNS[i];
        end
      end
    end
    h = HEADING_ZERO - z;
    rounded = {1'b0, h} + 25'd128;
    f.heading = rounded[23:8];
    f.clean_x = cx[SAMPLE_BITS-1:0];
    f.clean_y = cy[SAMPLE_BITS-1:0];
    f.sensor_heading = s.sensor_heading;
    return f;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Drive one sample and hold it until the block takes it
  task automatic offer_sample(mag_sample_t s);
    in_tdata <= {s.sensor_heading, s.mag_y, s.mag_x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Drop valid and wait for every outstanding fix
  task automatic wait_for_fixes();
    in_tvalid <= 1'b0;
    while (fixes_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {8'($urandom), 24'(value)};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_X_OFFSET:  cal_x_offset = 24'(value);
      REG_Y_OFFSET:  cal_y_offset = 24'(value);
      REG_X_SCALE:   cal_x_scale = 24'(value);
      REG_Y_SCALE:   cal_y_scale = 24'(value);
      REG_THRESHOLD: cal_threshold = 24'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(int xo, int yo, int xs, int ys, int thr);
    write_reg(REG_X_OFFSET, xo);
    write_reg(REG_Y_OFFSET, yo);
    write_reg(REG_X_SCALE, xs);
    write_reg(REG_Y_SCALE, ys);
    write_reg(REG_THRESHOLD, thr);
    settings_applied++;
  endtask

  // Check each fix against the oldest prediction
  always @(posedge clk) begin : fix_monitor
    fix_t seen, due;
    if (rst_n && out_tvalid && out_tready) begin
      seen.heading = out_tdata[HEAD_W-1:0];
      seen.clean_x = out_tdata[HEAD_W +: SAMPLE_BITS];
      seen.clean_y = out_tdata[HEAD_W+SAMPLE_BITS +: SAMPLE_BITS];
      seen.sensor_heading = out_tdata[HEAD_W+2*SAMPLE_BITS +: HEAD_W];
      if (fixes_due.size() == 0) begin
        report_mismatch($sformatf("fix with none pending, heading %0d", seen.heading));
      end else begin
        due = fixes_due.pop_front();
        if (seen.heading !== due.heading)
          report_mismatch($sformatf("heading %0d, want %0d", seen.heading, due.heading));
        if (seen.clean_x !== due.clean_x)
          report_mismatch($sformatf("clean_x %0d, want %0d", seen.clean_x, due.clean_x));
        if (seen.clean_y !== due.clean_y)
          report_mismatch($sformatf("clean_y %0d, want %0d", seen.clean_y, due.clean_y));
        if (seen.sensor_heading !== due.sensor_heading)
          report_mismatch($sformatf("sensor_heading %0d, want %0d",
                                    seen.sensor_heading, due.sensor_heading));
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    @(posedge clk);
    forever begin
      if (rx_hold_off) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold_off = 1'b0;
      end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // End the run if no handshake of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR @%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    mag_sample_t s;
    fix_t want;
    longint base_x, base_y, step_x, step_y, jump_amp, noise_amp;
    int step_left;
    bit tx_bursts;
    bit hold_window;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_for_fixes();
        write_reg(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        s.mag_x = 24'(directed_rows[r].mx);
        s.mag_y = 24'(directed_rows[r].my);
        s.sensor_heading = 16'(directed_rows[r].hdg);
        offer_sample(s);
        want = predict_fix(s);
        if (directed_rows[r].pinned) begin
          want.heading = 16'(directed_rows[r].e_head);
          want.clean_x = 24'(directed_rows[r].e_cx);
          want.clean_y = 24'(directed_rows[r].e_cy);
          want.sensor_heading = 16'(directed_rows[r].hdg);
        end
        fixes_due.push_back(want);
      end
    end

    // Random phases, each under its own calibration
    step_left = 0;
    step_x = 0;
    step_y = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_fixes();
      case (p)
        0: apply_setting(151, 243, 189713, 153987, $urandom_range(0, 400));
        1: apply_setting(SAMPLE_BOTTOM, SAMPLE_TOP, CFG_FULL, CFG_FULL, 0);
        2: apply_setting(SAMPLE_TOP, SAMPLE_BOTTOM, 0, CFG_FULL, CFG_FULL);
        default: apply_setting(
          int'($urandom), int'($urandom),
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : int'($urandom),
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : int'($urandom),
          ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 2000));
      endcase
      // Steady flow in phase 3 and in the last phase, bursts in all others
      tx_bursts = (p != 3 && p != NUM_PHASES - 1);
      rx_bursts = tx_bursts;
      jump_amp = (cal_threshold > 24'd1000000) ? 64'sd16777215
                                               : 3 * longint'(cal_threshold) + 64;
      noise_amp = jump_amp / 16 + 1;
      base_x = longint'($signed(24'($urandom)));
      base_y = longint'($signed(24'($urandom)));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        hold_window = (p == 1 && n >= 20 && n < 40);
        if (p == 1 && n == 20) rx_hold_off = 1'b1;
        if (p == 4 && n == 100) wait_for_fixes();

        if ($urandom_range(0, 7) == 0) begin
          // Noise: anything the sample fields allow
          s.mag_x = 24'($urandom);
          s.mag_y = 24'($urandom);
        end else begin
          // Slowly drifting field with occasional degauss steps
          if ($urandom_range(0, 63) == 0) begin
            base_x = longint'($signed(24'($urandom)));
            base_y = longint'($signed(24'($urandom)));
          end
          if (step_left == 0 && $urandom_range(0, 15) == 0) begin
            step_left = $urandom_range(1, 8);
            step_x = ($urandom_range(0, 2) == 0) ? 0 : signed_span(jump_amp);
            step_y = ($urandom_range(0, 2) == 0) ? 0 : signed_span(jump_amp);
          end
          base_x = base_x + signed_span(16);
          base_y = base_y + signed_span(16);
          s.mag_x = 24'(base_x + signed_span(noise_amp) + ((step_left != 0) ? step_x : 0));
          s.mag_y = 24'(base_y + signed_span(noise_amp) + ((step_left != 0) ? step_y : 0));
          if (step_left != 0) step_left--;
        end
        s.sensor_heading = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 36000));
        offer_sample(s);
        fixes_due.push_back(predict_fix(s));

        // Idle the input in bursts
        if (tx_bursts && !hold_window && $urandom_range(0, 5) == 0) begin
          in_tvalid <= 1'b0;
          in_tdata <= {$urandom, $urandom};
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
      end
    end

    // Drain, then watch for stray fixes
    wait_for_fixes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fixes_due.size() != 0)
      report_mismatch($sformatf("%0d fixes never arrived", fixes_due.size()));

    $display("Run: %0d samples (%0d directed rows), %0d calibration settings, %0d degauss holds",
             samples_sent, NUM_DIRECTED, settings_applied, holds_started);
    $display("Run: one %0d-cycle output hold-off with input backpressure, one mid-run drain",
             RX_HOLD_OFF_CYCLES);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/dgh_pkg.sv
hdl/dgh_queue.sv
hdl/dgh_front.sv
hdl/dgh_back.sv
hdl/magnetometer_degauss_heading.sv
tb/sv/magnetometer_degauss_heading_tb.sv
